// ----- hdl/fcs_pkg.sv -----
// Shared types, codes and helpers for the Fletcher checksum unit.
// No dependencies; fcs_front, fcs_back and the top level import this package.
package fcs_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ResultW = 64;
  localparam int unsigned WordQueueDepthDefault = 4;
  localparam int unsigned ResultQueueDepthDefault = 2;

  localparam logic [1:0] WidthF16 = 2'd0;
  localparam logic [1:0] WidthF32 = 2'd1;
  localparam logic [1:0] WidthF64 = 2'd2;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
    logic [1:0]       width;
  } word_entry_t;

  function automatic logic [WordW-1:0] width_mask(input logic [1:0] width);
    logic [WordW-1:0] m;
    case (width)
      WidthF16: m = 32'h0000_00ff;
      WidthF32: m = 32'h0000_ffff;
      default:  m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/fcs_queue.sv -----
// Small first-word-fall-through queue built from registers.
// Depends on nothing; used for the word queue and the result queue.
module fcs_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);

  logic [Width-1:0]  mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == FullCount);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

endmodule

// ----- hdl/fcs_front.sv -----
// Front end: holds the width register, accepts bytes and packs them into words.
// Depends on fcs_pkg; feeds completed words to the word queue.
module fcs_front
  import fcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        push_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        word_full_i,
  output logic        word_push_o,
  output word_entry_t word_entry_o
);

  logic [1:0]       width_q;
  logic [23:0]      word_bytes_q;
  logic [1:0]       byte_slot_q;
  logic [2:0]       slot_inc;
  logic [2:0]       word_size;
  logic [WordW-1:0] word;
  logic             accept;
  logic             complete;

  always_comb begin
    case (width_q)
      WidthF16: word_size = 3'd1;
      WidthF32: word_size = 3'd2;
      default:  word_size = 3'd4;
    endcase
    slot_inc = {1'b0, byte_slot_q} + 3'd1;
    word     = {8'b0, word_bytes_q} | ({24'b0, data_byte_i} << {byte_slot_q, 3'b000});
    complete = (slot_inc >= word_size) || last_byte_i;
    accept   = push_i && !word_full_i;
  end

  assign word_push_o        = accept && complete;
  assign word_entry_o.word  = word;
  assign word_entry_o.last  = last_byte_i;
  assign word_entry_o.width = width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WidthF16;
      word_bytes_q <= '0;
      byte_slot_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        width_q <= cfg_data_i;
      end
      if (accept) begin
        if (complete) begin
          word_bytes_q <= '0;
          byte_slot_q  <= '0;
        end else begin
          word_bytes_q <= word[23:0];
          byte_slot_q  <= slot_inc[1:0];
        end
      end
    end
  end

endmodule

// ----- hdl/fcs_back.sv -----
// Back end: two-stage running-sum pipeline, first sum then second sum.
// Depends on fcs_pkg; pops the word queue and pushes the result queue.
module fcs_back
  import fcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               word_valid_i,
  input  word_entry_t        word_entry_i,
  output logic               word_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output logic [ResultW-1:0] res_data_o
);

  function automatic logic [WordW-1:0] mod_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] m);
    logic [WordW:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[WordW-1:0];
  endfunction

  logic [WordW-1:0] sum_first_q, sum_second_q;
  logic [WordW-1:0] b_s1_q;
  logic             b_valid_q, b_last_q;
  logic [1:0]       b_width_q;
  logic [WordW-1:0] mask_a, mask_b, s1_new, s2_new;
  logic             back_en;

  always_comb begin
    mask_a = width_mask(word_entry_i.width);
    mask_b = width_mask(b_width_q);
    s1_new = mod_add(sum_first_q & mask_a, word_entry_i.word & mask_a, mask_a);
    s2_new = mod_add(sum_second_q & mask_b, b_s1_q, mask_b);
    case (b_width_q)
      WidthF16: res_data_o = {48'b0, s2_new[7:0], b_s1_q[7:0]};
      WidthF32: res_data_o = {32'b0, s2_new[15:0], b_s1_q[15:0]};
      default:  res_data_o = {s2_new, b_s1_q};
    endcase
  end

  assign back_en    = !(b_valid_q && b_last_q && res_full_i);
  assign word_pop_o = back_en && word_valid_i;
  assign res_push_o = back_en && b_valid_q && b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_first_q  <= '0;
      sum_second_q <= '0;
      b_s1_q       <= '0;
      b_valid_q    <= 1'b0;
      b_last_q     <= 1'b0;
      b_width_q    <= WidthF16;
    end else if (back_en) begin
      b_valid_q <= word_valid_i;
      if (word_valid_i) begin
        sum_first_q <= word_entry_i.last ? '0 : s1_new;
        b_s1_q      <= s1_new;
        b_last_q    <= word_entry_i.last;
        b_width_q   <= word_entry_i.width;
      end
      if (b_valid_q) begin
        sum_second_q <= b_last_q ? '0 : s2_new;
      end
    end
  end

endmodule

// ----- hdl/fletcher_checksum_unit.sv -----
// Top level of the Fletcher-16/32/64 checksum unit.
// Depends on fcs_pkg, fcs_front, fcs_queue and fcs_back.
//
// Usage: message bytes enter through push/full, one beat per byte, with
// last_byte_i set on the final byte. Each message yields one 64-bit checksum
// on the result side, read through empty/pop; checksum_o shows the oldest
// waiting result whenever empty is low. The width register (0: Fletcher-16,
// 1: Fletcher-32, 2 or 3: Fletcher-64) is written through the cfg channel,
// which is always ready; it should change only while no message is pending.
// Throughput is one byte per clock while full is low. The word that holds a
// final byte is written into the word queue, passes the first-sum stage
// register, and its second-sum result is then pushed into the result queue.
// The two sums sit in separate stages, so each stage holds a
// single modular add. When the receiver stops popping, the result queue and
// then the word queue fill and full rises; no beat is lost. Reset clears all
// sums, the byte packer and both queues and sets the width to Fletcher-16.
module fletcher_checksum_unit
  import fcs_pkg::*;
#(
  parameter int unsigned WordQueueDepth   = WordQueueDepthDefault,
  parameter int unsigned ResultQueueDepth = ResultQueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [ResultW-1:0] checksum_o
);

  localparam int unsigned EntryW = $bits(word_entry_t);

  word_entry_t        front_entry, back_entry;
  logic               word_push, word_full, word_pop, word_empty;
  logic               res_push, res_full;
  logic [ResultW-1:0] res_data;
  logic [EntryW-1:0]  back_entry_bits;

  assign cfg_ready_o = 1'b1;
  assign full        = word_full;
  assign back_entry  = word_entry_t'(back_entry_bits);

  fcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .word_full_i  (word_full),
    .word_push_o  (word_push),
    .word_entry_o (front_entry)
  );

  fcs_queue #(
    .Width (EntryW),
    .Depth (WordQueueDepth)
  ) u_word_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (word_push),
    .data_i  (front_entry),
    .full_o  (word_full),
    .pop_i   (word_pop),
    .data_o  (back_entry_bits),
    .empty_o (word_empty)
  );

  fcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (!word_empty),
    .word_entry_i (back_entry),
    .word_pop_o   (word_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_data_o   (res_data)
  );

  fcs_queue #(
    .Width (ResultW),
    .Depth (ResultQueueDepth)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (checksum_o),
    .empty_o (empty)
  );

  a_word_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_push |-> !word_full)
    else $error("Word pushed into a full word queue.");

  a_word_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_pop |-> !word_empty)
    else $error("Word popped from an empty word queue.");

  a_result_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("Result pushed into a full result queue.");

endmodule
